FILE: src/framewise_rmse_accumulator_unit_assert.svh
// Assertion macros for the RMSE accumulator
`ifndef FRAMEWISE_RMSE_ACCUMULATOR_UNIT_ASSERT_SVH
`define FRAMEWISE_RMSE_ACCUMULATOR_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define RMSE_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define RMSE_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: src/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared constants and types of the framewise RMSE accumulator.
// ----------------------------------------------------------------------------
package fra_pkg;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 32;
    localparam int RMSE_WIDTH   = 24;
    localparam int SUM_WIDTH    = 64;
    localparam int RSUM_WIDTH   = 56;
    localparam int ADDR_WIDTH   = 4;

    localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [1:0] REG_FRAME_BY_FRAME = 2'd1;
    localparam logic [1:0] REG_SKIP_ENABLE = 2'd2;
    localparam logic [1:0] REG_SKIP_VALUE = 2'd3;

    // kind of result division
    typedef enum logic [1:0] {
        DIV_RMSE = 2'd0,
        DIV_MEAN = 2'd1
    } div_kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic      accum;      // add the accepted pair
        logic      div_start;  // start the divider
        div_kind_t div_kind;
        logic      div_step;   // one divider bit
        logic      sqrt_start;
        logic      sqrt_step;
        logic      frame_add;  // fold frame RMSE into the running sum
        logic      frame_clr;
        logic      all_clr;
    } fra_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic used_zero;
        logic fcount_zero;
        logic frame_close;
        logic quot_ovf;
    } fra_stat_t;
endpackage

FILE: src/fra_if.sv
// ----------------------------------------------------------------------------
// fra_in_if / fra_out_if
// Valid/ready channels of the RMSE accumulator.
// ----------------------------------------------------------------------------
interface fra_in_if;
    import fra_pkg::*;
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_x;
    logic signed [SAMPLE_WIDTH-1:0] sample_y;
    logic                           end_of_stream;
    modport source (output valid, sample_x, sample_y, end_of_stream, input ready);
    modport sink (input valid, sample_x, sample_y, end_of_stream, output ready);
endinterface

interface fra_out_if;
    import fra_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [RMSE_WIDTH-1:0] rmse_value;
    logic                  is_final;
    logic                  status;
    modport source (output valid, rmse_value, is_final, status, input ready);
    modport sink (input valid, rmse_value, is_final, status, output ready);
endinterface

FILE: src/fra_datapath.sv
// ----------------------------------------------------------------------------
// fra_datapath
// Accumulators, bit-serial divider and bit-serial square root.
// ----------------------------------------------------------------------------
module fra_datapath
    import fra_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  fra_cmd_t                       cmd,
    output fra_stat_t                      stat,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_x,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_y,
    input  logic [15:0]                    frame_length,
    input  logic                           skip_enable,
    input  logic signed [SAMPLE_WIDTH-1:0] skip_value,
    output logic [RMSE_WIDTH-1:0]          rmse_out,
    output logic [RMSE_WIDTH-1:0]          mean_out
);
    localparam int DW = SUM_WIDTH + 16;
    localparam int AW = SAMPLE_WIDTH + 1;

    logic [SUM_WIDTH-1:0]   ssum_reg;
    logic [COUNT_WIDTH-1:0] ucnt_reg;
    logic [15:0]            fpos_reg;
    logic [RSUM_WIDTH-1:0]  rsum_reg;
    logic [COUNT_WIDTH-1:0] fcnt_reg;
    logic [DW-1:0]          dquo_reg;
    logic [COUNT_WIDTH-1:0] drem_reg;
    logic [COUNT_WIDTH-1:0] dden_reg;
    logic [47:0]            sval_reg;
    logic [47:0]            sres_reg;
    logic [47:0]            sbit_reg;

    // pair square, with skip test
    logic signed [AW-1:0] diff;
    logic [AW-1:0]        adiff;
    logic [2*AW-1:0]      sq;
    logic                 use_pair;
    logic [SUM_WIDTH:0]   ssum_add;
    assign use_pair = !skip_enable || (sample_x != skip_value && sample_y != skip_value);
    assign diff  = AW'(sample_x) - AW'(sample_y);
    assign adiff = diff[AW-1] ? AW'(-diff) : AW'(diff);
    assign sq    = adiff * adiff;
    assign ssum_add = {1'b0, ssum_reg} + (SUM_WIDTH+1)'(sq);

    logic [16:0] pos_inc;
    assign pos_inc = {1'b0, fpos_reg} + 17'd1;

    // divider step: shift the next dividend bit into the remainder
    logic [COUNT_WIDTH:0] rem_sh;
    logic                 rem_ge;
    assign rem_sh = {drem_reg, dquo_reg[DW-1]};
    assign rem_ge = rem_sh >= {1'b0, dden_reg};

    // square root step
    logic [47:0] s_try;
    assign s_try = sres_reg + sbit_reg;

    // frame RMSE, saturated when the mean square overflows
    logic                  quot_ovf;
    logic [RMSE_WIDTH-1:0] frame_rmse;
    assign quot_ovf   = dquo_reg[DW-1:48] != '0;
    assign frame_rmse = quot_ovf ? '1 : sres_reg[RMSE_WIDTH-1:0];

    logic [RSUM_WIDTH:0] rsum_add;
    assign rsum_add = {1'b0, rsum_reg} + (RSUM_WIDTH+1)'(frame_rmse);

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssum_reg <= '0;
            ucnt_reg <= '0;
            fpos_reg <= '0;
            rsum_reg <= '0;
            fcnt_reg <= '0;
        end
        else if (cmd.all_clr)
        begin
            ssum_reg <= '0;
            ucnt_reg <= '0;
            fpos_reg <= '0;
            rsum_reg <= '0;
            fcnt_reg <= '0;
        end
        else
        begin
            if (cmd.accum)
            begin
                if (use_pair)
                begin
                    ssum_reg <= ssum_add[SUM_WIDTH] ? '1 : ssum_add[SUM_WIDTH-1:0];
                    if (ucnt_reg != '1)
                    begin
                        ucnt_reg <= ucnt_reg + 1'b1;
                    end
                end
                if (frame_length != '0)
                begin
                    fpos_reg <= pos_inc[15:0];
                end
            end
            if (cmd.frame_add)
            begin
                rsum_reg <= rsum_add[RSUM_WIDTH] ? '1 : rsum_add[RSUM_WIDTH-1:0];
                if (fcnt_reg != '1)
                begin
                    fcnt_reg <= fcnt_reg + 1'b1;
                end
            end
            if (cmd.frame_clr)
            begin
                ssum_reg <= '0;
                ucnt_reg <= '0;
                fpos_reg <= '0;
            end
        end
    end

    // divider and square root registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            drem_reg <= '0;
            if (cmd.div_kind == DIV_RMSE)
            begin
                dquo_reg <= {ssum_reg, 16'd0};
                dden_reg <= ucnt_reg;
            end
            else
            begin
                dquo_reg <= DW'(rsum_reg);
                dden_reg <= fcnt_reg;
            end
        end
        else if (cmd.div_step)
        begin
            dquo_reg <= {dquo_reg[DW-2:0], rem_ge};
            drem_reg <= rem_ge ? COUNT_WIDTH'(rem_sh - {1'b0, dden_reg})
                               : rem_sh[COUNT_WIDTH-1:0];
        end
        if (cmd.sqrt_start)
        begin
            sval_reg <= dquo_reg[47:0];
            sres_reg <= '0;
            sbit_reg <= 48'd1 << 46;
        end
        else if (cmd.sqrt_step)
        begin
            if (sval_reg >= s_try)
            begin
                sval_reg <= sval_reg - s_try;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    assign stat.used_zero   = ucnt_reg == '0;
    assign stat.fcount_zero = fcnt_reg == '0;
    assign stat.frame_close = frame_length != '0 && pos_inc >= {1'b0, frame_length};
    assign stat.quot_ovf    = quot_ovf;
    assign rmse_out = sres_reg[RMSE_WIDTH-1:0];
    assign mean_out = dquo_reg[RMSE_WIDTH-1:0];
endmodule

FILE: src/fra_ctrl.sv
// ----------------------------------------------------------------------------
// fra_ctrl
// Sequencer: accepts pairs, runs divider and root at frame and stream end.
// ----------------------------------------------------------------------------
module fra_ctrl
    import fra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_eos,
    input  logic                  frame_by_frame,
    input  logic                  len_zero,
    output fra_cmd_t              cmd,
    input  fra_stat_t             stat,
    input  logic [RMSE_WIDTH-1:0] rmse_in,
    input  logic [RMSE_WIDTH-1:0] mean_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [RMSE_WIDTH-1:0] out_rmse,
    output logic                  out_final,
    output logic                  out_status
);
    localparam int DSTEPS = SUM_WIDTH + 16;
    localparam int SSTEPS = 24;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DECIDE = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_SQRT  = 6'b001000,
        ST_POST  = 6'b010000,
        ST_FINAL = 6'b100000
    } state_t;

    state_t    state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic      eos_reg, eos_next;
    logic      close_reg, close_next;
    logic      kind_reg, kind_next;   // 1 while computing the final mean
    logic      ov_reg, ov_next;
    logic [RMSE_WIDTH-1:0] orm_reg, orm_next;
    logic      ofin_reg, ofin_next;
    logic      ost_reg, ost_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            eos_reg   <= 1'b0;
            close_reg <= 1'b0;
            kind_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            eos_reg   <= eos_next;
            close_reg <= close_next;
            kind_reg  <= kind_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        orm_reg  <= orm_next;
        ofin_reg <= ofin_next;
        ost_reg  <= ost_next;
    end

    logic out_free;
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        eos_next   = eos_reg;
        close_next = close_reg;
        kind_next  = kind_reg;
        ov_next    = ov_reg && !out_ready;
        orm_next   = orm_reg;
        ofin_next  = ofin_reg;
        ost_next   = ost_reg;
        cmd        = '0;
        cmd.div_kind = DIV_RMSE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accum  = 1'b1;
                    eos_next   = in_eos;
                    close_next = stat.frame_close;
                    state_next = (stat.frame_close || in_eos) ? ST_DECIDE : ST_IDLE;
                end
            end
            ST_DECIDE:
            begin
                // frame close (or whole-stream end) with used pairs needs a root
                if ((close_reg || (eos_reg && len_zero)) && !stat.used_zero)
                begin
                    cmd.div_start = 1'b1;
                    kind_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else if (close_reg && frame_by_frame)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1; orm_next = '0; ofin_next = 1'b0; ost_next = 1'b1;
                        cmd.frame_clr = 1'b1;
                        close_next = 1'b0;
                        state_next = eos_reg ? ST_FINAL : ST_IDLE;
                    end
                end
                else
                begin
                    if (close_reg)
                    begin
                        cmd.frame_clr = 1'b1;
                    end
                    close_next = 1'b0;
                    state_next = eos_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 7'(DSTEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = kind_reg ? ST_POST : ST_SQRT;
                    cmd.sqrt_start = 1'b0;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    cmd.sqrt_start = 1'b1;
                    cnt_next = 7'd1;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 7'(SSTEPS))
                    begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_POST:
            begin
                if (kind_reg)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1; orm_next = mean_in; ofin_next = 1'b1; ost_next = 1'b0;
                        cmd.all_clr = 1'b1;
                        kind_next  = 1'b0;
                        eos_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else if (close_reg && !frame_by_frame)
                begin
                    cmd.frame_add = 1'b1;
                    cmd.frame_clr = 1'b1;
                    close_next = 1'b0;
                    state_next = eos_reg ? ST_FINAL : ST_IDLE;
                end
                else if (out_free)
                begin
                    ov_next  = 1'b1;
                    orm_next = stat.quot_ovf ? '1 : rmse_in;
                    ost_next = 1'b0;
                    if (close_reg)
                    begin
                        ofin_next = 1'b0;
                        cmd.frame_clr = 1'b1;
                        close_next = 1'b0;
                        state_next = eos_reg ? ST_FINAL : ST_IDLE;
                    end
                    else
                    begin
                        ofin_next = 1'b1;
                        cmd.all_clr = 1'b1;
                        eos_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FINAL:
            begin
                if (!len_zero && frame_by_frame)
                begin
                    cmd.all_clr = 1'b1;
                    eos_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (!len_zero && !stat.fcount_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_kind  = DIV_MEAN;
                    kind_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else if (out_free)
                begin
                    ov_next = 1'b1; orm_next = '0; ofin_next = 1'b1; ost_next = 1'b1;
                    cmd.all_clr = 1'b1;
                    eos_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = ov_reg;
    assign out_rmse   = orm_reg;
    assign out_final  = ofin_reg;
    assign out_status = ost_reg;

`include "framewise_rmse_accumulator_unit_assert.svh"
    `RMSE_ASSERT_IMP(a_ready_idle, in_ready, state_reg == ST_IDLE)
    `RMSE_ASSERT_NXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(out_rmse))
    `RMSE_ASSERT_IMP(a_empty_zero, out_valid && out_status, out_rmse == '0)
endmodule

FILE: src/framewise_rmse_accumulator_unit.sv
// ----------------------------------------------------------------------------
// framewise_rmse_accumulator_unit
// Framewise RMSE of two signed sample streams, Q16.8 result.
// ----------------------------------------------------------------------------
// Pairs arrive on the in channel (sample_x, sample_y, end_of_stream) and
// results leave on the out channel (rmse_value, is_final, status); both
// transfer when valid and ready are high at a clock edge. The user must
// write registers over the APB port at byte addresses 0, 4, 8, 12 only
// while idle; the block does not enforce this. A pair that closes neither a
// frame nor the stream is taken in the idle state; a pair that reaches a
// frame end or carries end_of_stream also passes the decide state. A root
// costs 80 divider steps, a root load, 24 root steps and the post state;
// divider and root make one bit a cycle, and the final mean costs another
// 80 divider steps. The result register holds its value while the receiver
// stalls; the sequencer waits only to hand over a new result. Reset clears
// all accumulators and the registers, and the block is ready at once.
// ----------------------------------------------------------------------------
module framewise_rmse_accumulator_unit
    import fra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fra_in_if.sink                in_ch,
    fra_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic [15:0]                    flen_reg;
    logic                           fbf_reg;
    logic                           sken_reg;
    logic signed [SAMPLE_WIDTH-1:0] skval_reg;
    fra_cmd_t                       cmd;
    fra_stat_t                      stat;
    logic [RMSE_WIDTH-1:0]          rmse_w, mean_w;

    assign pready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flen_reg <= '0; fbf_reg <= 1'b0; sken_reg <= 1'b0; skval_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_FRAME_LENGTH:   flen_reg  <= pwdata[15:0];
                REG_FRAME_BY_FRAME: fbf_reg   <= pwdata[0];
                REG_SKIP_ENABLE:    sken_reg  <= pwdata[0];
                REG_SKIP_VALUE:     skval_reg <= pwdata[SAMPLE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_LENGTH:   prdata = {16'd0, flen_reg};
            REG_FRAME_BY_FRAME: prdata = {31'd0, fbf_reg};
            REG_SKIP_ENABLE:    prdata = {31'd0, sken_reg};
            REG_SKIP_VALUE:     prdata = 32'(unsigned'(skval_reg));
            default:            prdata = '0;
        endcase
    end

    fra_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .sample_x(in_ch.sample_x), .sample_y(in_ch.sample_y),
        .frame_length(flen_reg), .skip_enable(sken_reg), .skip_value(skval_reg),
        .rmse_out(rmse_w), .mean_out(mean_w)
    );

    fra_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_eos(in_ch.end_of_stream),
        .frame_by_frame(fbf_reg), .len_zero(flen_reg == '0),
        .cmd(cmd), .stat(stat), .rmse_in(rmse_w), .mean_in(mean_w),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_rmse(out_ch.rmse_value), .out_final(out_ch.is_final),
        .out_status(out_ch.status)
    );
endmodule

FILE: tb/tb_framewise_rmse_accumulator_unit.sv
// ----------------------------------------------------------------------------
// tb_framewise_rmse_accumulator_unit
// Self-checking bench for the framewise RMSE accumulator.
// ----------------------------------------------------------------------------
// Sample pairs are queued per configuration phase and predicted when queued,
// in transfer order. A clocked driver feeds the input channel with random
// gaps, and a clocked monitor stalls the output at random and compares each
// result with the oldest prediction. Registers change over APB only once
// the block has drained.
// ----------------------------------------------------------------------------
module tb_framewise_rmse_accumulator_unit;
    import fra_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_x;
        logic signed [SAMPLE_WIDTH-1:0] sample_y;
        logic                           end_of_stream;
    } pair_t;

    typedef struct packed {
        logic [RMSE_WIDTH-1:0] rmse_value;
        logic                  is_final;
        logic                  status;
    } rmse_res_t;

    localparam int DRAIN_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    fra_in_if  in_ch ();
    fra_out_if out_ch ();

    framewise_rmse_accumulator_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pair_t     pending_pairs[$];
    rmse_res_t expected_rmse[$];
    int        mismatches;
    int        send_gap;
    int        recv_stall;
    bit        quiet;

    // register shadow and accumulator state of the predictor
    logic [15:0]              cfg_length;
    logic                     cfg_fbf;
    logic                     cfg_skip_en;
    logic signed [15:0]       cfg_skip_val;
    logic [SUM_WIDTH-1:0]     acc_square;
    logic [COUNT_WIDTH-1:0]   acc_used;
    logic [15:0]              acc_pos;
    logic [RSUM_WIDTH-1:0]    acc_rmse;
    logic [COUNT_WIDTH-1:0]   acc_frames;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("** framewise_rmse_accumulator_unit: FAILED **");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] root;
        logic [63:0] probe;
        root = 64'd0;
        probe = 64'd1 << 62;
        while (probe > val)
            probe = probe >> 2;
        while (probe != 64'd0)
        begin
            if (val >= root + probe)
            begin
                val = val - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Q16.8 root of sum/count, count nonzero
    function automatic logic [RMSE_WIDTH-1:0] q_rmse(input logic [63:0] sum,
                                                     input logic [63:0] count);
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] mean_sq;
        quo = sum / count;
        rem = sum % count;
        if (quo >= 64'h1_0000_0000)
            return '1;
        mean_sq = (quo << 16) + ((rem << 16) / count);
        return RMSE_WIDTH'(int_sqrt(mean_sq));
    endfunction

    function automatic void clear_accum();
        acc_square = '0;
        acc_used = '0;
        acc_pos = '0;
        acc_rmse = '0;
        acc_frames = '0;
    endfunction

    // advance the accumulator by one pair, queue any result it produces
    function automatic void predict_rmse(input pair_t p);
        longint             diff;
        logic [64:0]        wide;
        logic [56:0]        wide_r;
        logic [16:0]        pos;
        logic [RMSE_WIDTH-1:0] val;
        logic               empty;
        rmse_res_t          res;
        if (!cfg_skip_en || (p.sample_x != cfg_skip_val && p.sample_y != cfg_skip_val))
        begin
            diff = longint'(p.sample_x) - longint'(p.sample_y);
            if (diff < 0)
                diff = -diff;
            wide = {1'b0, acc_square} + 65'(diff * diff);
            acc_square = wide[64] ? '1 : wide[63:0];
            if (acc_used != '1)
                acc_used = acc_used + 1'b1;
        end
        if (cfg_length != 16'd0)
        begin
            pos = {1'b0, acc_pos} + 17'd1;
            if (pos >= {1'b0, cfg_length})
            begin
                empty = (acc_used == '0);
                val = empty ? '0 : q_rmse(acc_square, 64'(acc_used));
                if (cfg_fbf)
                begin
                    res.rmse_value = val;
                    res.is_final = 1'b0;
                    res.status = empty;
                    expected_rmse.push_back(res);
                end
                else if (!empty)
                begin
                    wide_r = {1'b0, acc_rmse} + 57'(val);
                    acc_rmse = wide_r[56] ? '1 : wide_r[55:0];
                    if (acc_frames != '1)
                        acc_frames = acc_frames + 1'b1;
                end
                acc_square = '0;
                acc_used = '0;
                acc_pos = '0;
            end
            else
                acc_pos = pos[15:0];
            if (p.end_of_stream && !cfg_fbf)
            begin
                res.is_final = 1'b1;
                res.status = (acc_frames == '0);
                res.rmse_value = res.status ? '0 : RMSE_WIDTH'(acc_rmse / acc_frames);
                expected_rmse.push_back(res);
            end
        end
        else if (p.end_of_stream)
        begin
            res.is_final = 1'b1;
            res.status = (acc_used == '0);
            res.rmse_value = res.status ? '0 : q_rmse(acc_square, 64'(acc_used));
            expected_rmse.push_back(res);
        end
        if (p.end_of_stream)
            clear_accum();
    endfunction

    function automatic void queue_pair(input logic [15:0] sx, input logic [15:0] sy,
                                       input logic eos);
        pair_t p;
        p.sample_x = sx;
        p.sample_y = sy;
        p.end_of_stream = eos;
        predict_rmse(p);
        pending_pairs.push_back(p);
    endfunction

    // bias toward extremes and the skip value so skips and saturation occur
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return cfg_skip_val;
            4: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // hold until every queued pair is taken and every result has arrived
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || in_ch.valid || expected_rmse.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] len, input logic fbf,
                              input logic skip_en, input logic [15:0] skip_val);
        wait_drained();
        apb_write(REG_FRAME_LENGTH, {16'd0, len});
        apb_write(REG_FRAME_BY_FRAME, {31'd0, fbf});
        apb_write(REG_SKIP_ENABLE, {31'd0, skip_en});
        apb_write(REG_SKIP_VALUE, {16'd0, skip_val});
        cfg_length = len;
        cfg_fbf = fbf;
        cfg_skip_en = skip_en;
        cfg_skip_val = skip_val;
    endtask

    task automatic random_phase(input int count, input int eos_odds);
        for (int i = 0; i < count; i++)
            queue_pair(pick_sample(), pick_sample(), $urandom_range(0, eos_odds - 1) == 0);
    endtask

    // drive the input channel, with random gap bursts between transfers
    always @(posedge clk or negedge rst_n)
    begin
        pair_t p;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else if (in_ch.valid && !in_ch.ready)
            ;
        else if (send_gap > 0)
        begin
            in_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_pairs.size() != 0)
        begin
            p = pending_pairs.pop_front();
            in_ch.valid <= 1'b1;
            in_ch.sample_x <= p.sample_x;
            in_ch.sample_y <= p.sample_y;
            in_ch.end_of_stream <= p.end_of_stream;
            if (!quiet && $urandom_range(0, 7) == 0)
                send_gap <= $urandom_range(1, 14);
        end
        else
            in_ch.valid <= 1'b0;
    end

    // stall the output at random and check each transfer
    always @(posedge clk or negedge rst_n)
    begin
        rmse_res_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_rmse.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: rmse=%h final=%b status=%b",
                                 out_ch.rmse_value, out_ch.is_final, out_ch.status);
                end
                else
                begin
                    want = expected_rmse.pop_front();
                    if (out_ch.rmse_value !== want.rmse_value
                        || out_ch.is_final !== want.is_final
                        || out_ch.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: rmse exp %h got %h, ",
                                      "final exp %b got %b, status exp %b got %b"},
                                     want.rmse_value, out_ch.rmse_value, want.is_final,
                                     out_ch.is_final, want.status, out_ch.status);
                    end
                end
            end
            if (recv_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    recv_stall <= $urandom_range(1, 14);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_x = '0;
        in_ch.sample_y = '0;
        in_ch.end_of_stream = 1'b0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        quiet = 1'b0;
        cfg_length = '0;
        cfg_fbf = 1'b0;
        cfg_skip_en = 1'b0;
        cfg_skip_val = '0;
        clear_accum();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // whole-stream mode at reset defaults: extremes, then two short streams
        queue_pair(16'h8000, 16'h7FFF, 1'b1);
        queue_pair(16'h7FFF, 16'h8000, 1'b0);
        queue_pair(16'h0000, 16'h0000, 1'b1);
        queue_pair(16'hFFFF, 16'h0001, 1'b1);

        // skipped pairs: an empty stream and an empty frame
        set_config(16'd0, 1'b1, 1'b1, 16'h8000);
        queue_pair(16'h8000, 16'h1234, 1'b0);
        queue_pair(16'h0005, 16'h8000, 1'b1);
        set_config(16'd2, 1'b1, 1'b1, 16'h7FFF);
        queue_pair(16'h7FFF, 16'h0000, 1'b0);
        queue_pair(16'h0000, 16'h7FFF, 1'b0);
        queue_pair(16'h0003, 16'h0001, 1'b0);
        queue_pair(16'h0004, 16'h0001, 1'b1);
        queue_pair(16'h0009, 16'h0000, 1'b1);

        // average mode: empty mean, frame closed by last pair, partial frame
        set_config(16'd3, 1'b0, 1'b1, 16'h0000);
        queue_pair(16'h0000, 16'h0001, 1'b1);
        for (int i = 0; i < 6; i++)
            queue_pair(16'(i * 7 + 1), 16'hFFF0, i == 5);
        queue_pair(16'h0010, 16'h0001, 1'b0);
        queue_pair(16'h0020, 16'h0002, 1'b0);
        queue_pair(16'h0030, 16'h0003, 1'b0);
        queue_pair(16'h0040, 16'h0004, 1'b1);

        // frame length lowered in mid-frame
        set_config(16'd16, 1'b1, 1'b0, 16'h0000);
        random_phase(9, 1000);
        set_config(16'd3, 1'b1, 1'b0, 16'h0000);
        queue_pair(16'h0100, 16'h0000, 1'b0);
        queue_pair(16'h0200, 16'h0000, 1'b1);

        // random phases across settings
        set_config(16'd1, 1'b1, 1'b0, 16'($urandom));
        random_phase(90, 30);
        set_config(16'd1, 1'b0, 1'b1, 16'h0000);
        random_phase(90, 15);
        set_config(16'd4, 1'b1, 1'b1, 16'($urandom));
        random_phase(100, 40);
        set_config(16'd5, 1'b0, 1'b1, 16'hFFFF);
        random_phase(100, 12);
        set_config(16'd0, 1'b0, 1'b1, 16'($urandom));
        random_phase(100, 10);
        set_config(16'd0, 1'b1, 1'b0, 16'h0000);
        random_phase(80, 8);
        set_config(16'hFFFF, 1'b0, 1'b0, 16'h8000);
        random_phase(80, 10);
        set_config(16'hFFFF, 1'b1, 1'b1, 16'h7FFF);
        random_phase(40, 8);
        set_config(16'd2, 1'b0, 1'b0, 16'($urandom));
        random_phase(100, 20);
        set_config(16'd7, 1'b1, 1'b1, 16'($urandom));
        random_phase(110, 50);
        set_config(16'($urandom_range(1, 9)), 1'($urandom), 1'b1, 16'($urandom));
        random_phase(110, 25);

        // final stretch with no idling on either side
        set_config(16'd3, 1'b1, 1'b1, 16'h0000);
        quiet = 1'b1;
        random_phase(120, 30);
        wait_drained();

        if (mismatches == 0)
            $display("** framewise_rmse_accumulator_unit: PASSED **");
        else
            $display("** framewise_rmse_accumulator_unit: FAILED **");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/fra_pkg.sv
src/fra_if.sv
src/fra_datapath.sv
src/fra_ctrl.sv
src/framewise_rmse_accumulator_unit.sv
tb/tb_framewise_rmse_accumulator_unit.sv
